@@ rtl/wsp_pkg.sv @@
package wsp_pkg;

   localparam int LEN_W      = 6;
   localparam int WORD_W     = 64;
   localparam int WORD_COUNT = 4;
   localparam int INDEX_W    = 3;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_STAR = 8'h2A;

   typedef enum logic [INDEX_W-1:0] {
      REG_WORD_0 = 3'd0,
      REG_WORD_1 = 3'd1,
      REG_WORD_2 = 3'd2,
      REG_WORD_3 = 3'd3,
      REG_LENGTH = 3'd4
   } reg_index_type;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_APPEND = 1'b1
   } opcode_type;

   // per-position settings derived from the pattern
   typedef struct packed {
      logic origin;
      logic in_range;
      logic elem;
      logic starred;
   } cell_cfg_type;

   typedef struct packed {
      logic full_match;
      logic still_alive;
   } status_type;

endpackage

@@ rtl/wsp_cell.sv @@
module wsp_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  wsp_pkg::opcode_type  opcode,
   input  logic [7:0]           text_char,
   input  logic [7:0]           pat_char,
   input  wsp_pkg::cell_cfg_type cfg,
   input  logic                 cur_skip_in,
   input  logic                 next_skip_in,
   input  logic                 move_in,
   output logic                 cur_skip_out,
   output logic                 next_skip_out,
   output logic                 move_out,
   output logic                 next_bit
);
   import wsp_pkg::*;

   logic active_ff;
   logic active_in;
   logic cur;
   logic hit;
   logic next_pre;

   always_comb begin
      cur          = (active_ff & cfg.in_range) | cur_skip_in;
      cur_skip_out = cur & cfg.starred;
      hit          = cur & cfg.elem & ((pat_char == text_char) || (pat_char == CHAR_DOT));
      move_out     = hit & ~cfg.starred;
      if (opcode == OP_APPEND) begin
         next_pre = move_in | (hit & cfg.starred);
      end else begin
         next_pre = cfg.origin;
      end
      next_bit      = next_pre | next_skip_in;
      next_skip_out = next_bit & cfg.starred;
      active_in     = advance ? next_bit : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= cfg.origin;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

@@ rtl/wsp_chain.sv @@
module wsp_chain #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  wsp_pkg::opcode_type          opcode,
   input  logic [7:0]                   text_char,
   input  logic [8*MAX_PATTERN-1:0]     pattern,
   input  logic [wsp_pkg::LEN_W-1:0]    len_eff,
   output wsp_pkg::status_type          status
);
   import wsp_pkg::*;

   localparam int CELLS = MAX_PATTERN + 1;

   logic [CELLS-1:0] cur_skip;
   logic [CELLS-1:0] next_skip;
   logic [CELLS-1:0] move;
   logic [CELLS-1:0] next_set;
   logic [CELLS-1:0] at_end;

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      cell_cfg_type cfg;
      logic [7:0]   pat_char;
      logic         cur_skip_in;
      logic         next_skip_in;
      logic         move_in;

      if (j < MAX_PATTERN) begin : g_char
         assign pat_char = pattern[8*j +: 8];
      end else begin : g_nochar
         assign pat_char = 8'h00;
      end

      if (j + 1 < MAX_PATTERN) begin : g_star
         assign cfg.starred = (LEN_W'(j + 1) < len_eff) && (pattern[8*(j+1) +: 8] == CHAR_STAR);
      end else begin : g_nostar
         assign cfg.starred = 1'b0;
      end

      if (j >= 2) begin : g_skip
         assign cur_skip_in  = cur_skip[j-2];
         assign next_skip_in = next_skip[j-2];
      end else begin : g_noskip
         assign cur_skip_in  = 1'b0;
         assign next_skip_in = 1'b0;
      end

      if (j >= 1) begin : g_move
         assign move_in = move[j-1];
      end else begin : g_nomove
         assign move_in = 1'b0;
      end

      assign cfg.origin   = (j == 0);
      assign cfg.in_range = LEN_W'(j) <= len_eff;
      assign cfg.elem     = LEN_W'(j) < len_eff;
      assign at_end[j]    = LEN_W'(j) == len_eff;

      wsp_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .opcode        (opcode),
         .text_char     (text_char),
         .pat_char      (pat_char),
         .cfg           (cfg),
         .cur_skip_in   (cur_skip_in),
         .next_skip_in  (next_skip_in),
         .move_in       (move_in),
         .cur_skip_out  (cur_skip[j]),
         .next_skip_out (next_skip[j]),
         .move_out      (move[j]),
         .next_bit      (next_set[j])
      );
   end

   always_comb begin
      status.full_match  = |(next_set & at_end);
      status.still_alive = |next_set;
   end

endmodule

@@ rtl/wildcard_star_pattern_matcher.sv @@
// Whole-text matcher for patterns of literal bytes, '.' and 'x*' held in four 64-bit pattern
// words plus a length. Each request either starts a new empty text or appends one byte, and
// yields one response: whether the text so far matches the whole pattern and whether any
// pattern position is still reachable. One byte is taken every clock cycle while req_stall is
// low. Its response is registered in a two-entry output stage that keeps requests flowing
// while one response waits; req_stall rises only when both are full. The per-byte update
// runs combinationally through a row of MAX_PATTERN+1 position cells, the closure over
// starred elements rippling from cell to cell, so that row sets the clock period.
module wildcard_star_pattern_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [7:0]                    req_text_char,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_full_match,
   output logic                          rsp_still_alive,
   input  logic                          csr_write,
   input  logic [wsp_pkg::INDEX_W-1:0]   csr_index,
   input  logic [wsp_pkg::WORD_W-1:0]    csr_wdata
);
   import wsp_pkg::*;

   logic [WORD_W-1:0]            word_ff [WORD_COUNT];
   logic [LEN_W-1:0]             len_ff;
   logic [LEN_W-1:0]             len_eff;
   logic [WORD_COUNT*WORD_W-1:0] pattern_all;

   logic       req_take;
   logic       rsp_take;
   status_type status;

   logic       out_valid_ff, out_valid_in;
   status_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   status_type skid_ff, skid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORD_COUNT; i++) begin
            word_ff[i] <= '0;
         end
         len_ff <= '0;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_WORD_0: word_ff[0] <= csr_wdata;
            REG_WORD_1: word_ff[1] <= csr_wdata;
            REG_WORD_2: word_ff[2] <= csr_wdata;
            REG_WORD_3: word_ff[3] <= csr_wdata;
            REG_LENGTH: len_ff     <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern_all = {word_ff[3], word_ff[2], word_ff[1], word_ff[0]};
   assign len_eff     = (len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_ff;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid & ~skid_valid_ff;
   assign rsp_take  = out_valid_ff & ~rsp_stall;

   wsp_chain #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_take),
      .opcode    (opcode_type'(req_opcode)),
      .text_char (req_text_char),
      .pattern   (pattern_all[8*MAX_PATTERN-1:0]),
      .len_eff   (len_eff),
      .status    (status)
   );

   // output register plus skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = status;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = status;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_full_match  = out_ff.full_match;
   assign rsp_still_alive = out_ff.still_alive;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_match_is_alive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_ff.full_match || out_ff.still_alive))
      else $error("full match reported with no live position");

   a_transfer_lands: assert property (@(posedge clock) disable iff (reset)
      (req_take && !out_valid_ff) |=> out_valid_ff)
      else $error("accepted transfer produced no response");
`endif

endmodule

@@ test/wildcard_star_pattern_matcher_tb.sv @@
`timescale 1ns / 1ps

module wildcard_star_pattern_matcher_tb;
   import wsp_pkg::*;

   localparam int MAX_PATTERN   = 32;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [7:0] LETTER_A = "a";
   localparam logic [7:0] LETTER_B = "b";

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_opcode;
   logic [7:0]          req_text_char;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_full_match;
   logic                rsp_still_alive;
   logic                csr_write;
   logic [INDEX_W-1:0]  csr_index;
   logic [WORD_W-1:0]   csr_wdata;

   // own copy of the matcher state and registers
   logic [WORD_W-1:0]   model_word [WORD_COUNT] = '{default: '0};
   logic [LEN_W-1:0]    model_len_reg = '0;
   logic [32:0]         model_active = 33'd1;

   status_type          pending_status [$];

   // pattern being built for the next load
   logic [7:0]          plan_char [MAX_PATTERN];
   logic [LEN_W-1:0]    plan_len_reg;
   int                  plan_len;

   int                  req_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  items_sent = 0;
   int                  mismatch_count = 0;
   int unsigned         cycle_count = 0;

   wildcard_star_pattern_matcher #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_text_char   (req_text_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_full_match  (rsp_full_match),
      .rsp_still_alive (rsp_still_alive),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("wildcard_star_pattern_matcher regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // ---------------------------------------------------------------- prediction

   function automatic int effective_len();
      return (model_len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(model_len_reg);
   endfunction

   function automatic logic [7:0] pattern_char(int j);
      return model_word[j / 8][(j % 8) * 8 +: 8];
   endfunction

   function automatic bit is_starred(int j, int len);
      return (j + 1 < len) && (pattern_char(j + 1) == CHAR_STAR);
   endfunction

   function automatic logic [32:0] close_positions(logic [32:0] set, int len);
      for (int j = 0; j < 33; j++)
         if (j > len) set[j] = 1'b0;
      for (int j = 0; j < len; j++)
         if (set[j] && is_starred(j, len)) set[j + 2] = 1'b1;
      return set;
   endfunction

   function automatic status_type advance_positions(opcode_type op, logic [7:0] ch);
      int          len;
      logic [32:0] cur;
      logic [32:0] nxt;
      logic [7:0]  pc;
      status_type  st;
      len = effective_len();
      nxt = '0;
      if (op == OP_START) begin
         nxt = close_positions(33'd1, len);
      end else begin
         cur = close_positions(model_active, len);
         for (int j = 0; j < len; j++) begin
            pc = pattern_char(j);
            if (cur[j] && (pc == ch || pc == CHAR_DOT)) begin
               if (is_starred(j, len)) nxt[j] = 1'b1;
               else nxt[j + 1] = 1'b1;
            end
         end
         nxt = close_positions(nxt, len);
      end
      model_active = nxt;
      st.full_match = nxt[len];
      st.still_alive = |nxt;
      return st;
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_rsp
      status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected transfer: full_match=%0b still_alive=%0b",
                        rsp_full_match, rsp_still_alive);
         end else begin
            want = pending_status.pop_front();
            if (want.full_match !== rsp_full_match || want.still_alive !== rsp_still_alive)
            begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected full_match=%0b still_alive=%0b, got %0b %0b",
                           want.full_match, want.still_alive,
                           rsp_full_match, rsp_still_alive);
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_item(opcode_type op, logic [7:0] ch);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_text_char <= ch;
      do @(posedge clock); while (req_stall);
      pending_status.push_back(advance_positions(op, ch));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx < WORD_COUNT) model_word[idx] = data;
      else if (idx == REG_LENGTH) model_len_reg = data[LEN_W-1:0];
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_plan(logic [WORD_W-1:0] len_data);
      logic [WORD_W-1:0] word;
      for (int w = 0; w < WORD_COUNT; w++) begin
         for (int b = 0; b < 8; b++) word[8 * b +: 8] = plan_char[8 * w + b];
         write_reg(INDEX_W'(int'(REG_WORD_0) + w), word);
      end
      write_reg(REG_LENGTH, len_data);
   endtask

   function automatic void set_plan(string s);
      for (int i = 0; i < MAX_PATTERN; i++)
         plan_char[i] = (i < s.len()) ? s[i] : 8'h00;
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void make_plan();
      int  roll;
      bit  noise;
      roll = $urandom_range(0, 99);
      if (roll < 60) plan_len_reg = LEN_W'($urandom_range(0, 8));
      else if (roll < 92) plan_len_reg = LEN_W'($urandom_range(9, 32));
      else plan_len_reg = LEN_W'($urandom_range(33, 63));
      plan_len = (plan_len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(plan_len_reg);
      noise = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         roll = $urandom_range(0, 99);
         if (noise || roll >= 90) plan_char[i] = random_byte();
         else if (roll < 35) plan_char[i] = LETTER_A;
         else if (roll < 55) plan_char[i] = LETTER_B;
         else if (roll < 70) plan_char[i] = CHAR_DOT;
         else plan_char[i] = CHAR_STAR;
      end
   endfunction

   // text that walks the plan, sometimes damaged or replaced by noise
   task automatic run_text();
      logic [7:0] txt [$];
      int j;
      int reps;
      int step;
      int roll;
      j = 0;
      while (j < plan_len) begin
         if (j + 1 < plan_len && plan_char[j + 1] == CHAR_STAR) begin
            reps = $urandom_range(0, 2);
            step = 2;
         end else begin
            reps = 1;
            step = 1;
         end
         repeat (reps)
            txt.push_back((plan_char[j] == CHAR_DOT) ? random_byte() : plan_char[j]);
         j += step;
      end
      roll = $urandom_range(0, 99);
      if (roll < 15 && txt.size() > 0) begin
         txt[$urandom_range(0, txt.size() - 1)] = random_byte();
      end else if (roll < 25 && txt.size() > 0) begin
         txt.delete($urandom_range(0, txt.size() - 1));
      end else if (roll < 35) begin
         txt.insert($urandom_range(0, txt.size()), random_byte());
      end else if (roll < 40) begin
         txt.delete();
         repeat ($urandom_range(0, 6)) txt.push_back(random_byte());
      end
      if ($urandom_range(0, 9) != 0) send_item(OP_START, random_byte());
      foreach (txt[k]) send_item(OP_APPEND, txt[k]);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      send_item(OP_APPEND, 8'hFF);
      send_item(OP_START, 8'h00);
   endtask

   task automatic test_field_extremes();
      wait_idle();
      set_plan("");
      plan_char[0] = 8'h00;
      plan_char[1] = 8'hFF;
      plan_char[2] = CHAR_DOT;
      load_plan(WORD_W'(3));
      send_item(OP_START, 8'hFF);
      send_item(OP_APPEND, 8'h00);
      send_item(OP_APPEND, 8'hFF);
      send_item(OP_APPEND, 8'h7F);
      send_item(OP_APPEND, 8'h80);
   endtask

   // leading star reads as a literal; in a doubled star the first is a literal that the second repeats
   task automatic test_star_rules();
      wait_idle();
      set_plan("*a**");
      load_plan(WORD_W'(4));
      send_item(OP_START, 8'h55);
      send_item(OP_APPEND, CHAR_STAR);
      send_item(OP_APPEND, LETTER_A);
      send_item(OP_APPEND, LETTER_A);
      send_item(OP_APPEND, CHAR_STAR);
   endtask

   task automatic test_length_over_max();
      wait_idle();
      for (int i = 0; i < MAX_PATTERN; i++)
         plan_char[i] = (i % 2 == 0) ? LETTER_A : CHAR_STAR;
      load_plan('1);
      send_item(OP_START, 8'hAA);
      send_item(OP_APPEND, LETTER_A);
      send_item(OP_APPEND, LETTER_A);
      send_item(OP_APPEND, LETTER_B);
   endtask

   task automatic test_config_mid_text();
      wait_idle();
      set_plan("ab*c");
      load_plan(WORD_W'(4));
      send_item(OP_START, 8'h00);
      send_item(OP_APPEND, LETTER_A);
      wait_idle();
      write_reg(REG_LENGTH, WORD_W'(2));
      send_item(OP_APPEND, LETTER_B);
   endtask

   task automatic test_spare_index();
      wait_idle();
      for (int i = int'(REG_LENGTH) + 1; i < (1 << INDEX_W); i++)
         write_reg(INDEX_W'(i), '1);
      send_item(OP_START, 8'h01);
      send_item(OP_APPEND, LETTER_A);
   endtask

   task automatic test_random_texts(int idle_pct, int stall_pct, int count);
      int               stop;
      logic [WORD_W-1:0] len_data;
      wait_idle();
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      stop = items_sent + count;
      while (items_sent < stop) begin
         wait_idle();
         make_plan();
         len_data = {$urandom(), $urandom()};
         len_data[LEN_W-1:0] = plan_len_reg;
         load_plan(len_data);
         repeat ($urandom_range(1, 6))
            if (items_sent < stop) run_text();
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_opcode    <= OP_START;
      req_text_char <= 8'h00;
      csr_write     <= 1'b0;
      csr_index     <= REG_WORD_0;
      csr_wdata     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_field_extremes();
      test_star_rules();
      test_length_over_max();
      test_config_mid_text();
      test_spare_index();
      test_random_texts(0, 0, 190);
      test_random_texts(73, 0, 190);
      test_random_texts(0, 73, 190);
      test_random_texts(11, 11, 190);

      wait_idle();
      if (mismatch_count == 0 && pending_status.size() == 0)
         $display("wildcard_star_pattern_matcher regression: pass");
      else
         $display("wildcard_star_pattern_matcher regression: fail");
      $finish;
   end

endmodule

@@ wildcard_star_pattern_matcher.f @@
rtl/wsp_pkg.sv
rtl/wsp_cell.sv
rtl/wsp_chain.sv
rtl/wildcard_star_pattern_matcher.sv
test/wildcard_star_pattern_matcher_tb.sv
